@@ hdl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/rir_pkg.sv @@
`default_nettype none

package rir_pkg;

	localparam int MAX_WINDOW_TERMS_DEF   = 256;
	localparam int TERM_FRACTION_BITS_DEF = 48;

	localparam int PRICE_W  = 32;
	localparam int VOL_W    = 32;
	localparam int PROD_W   = 64;
	localparam int SUM_W    = 64;
	localparam int TERM_W   = 56;
	localparam int WINDOW_W = 8;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd30;
	localparam logic [PRICE_W-1:0]  PRICE_ONE    = 32'h0001_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_TERM_GO,
		ST_TERM_WAIT,
		ST_UPDATE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_FINISH
	} rir_state_t;

	typedef struct packed {
		logic load_in;
		logic prep;
		logic div_start;
		logic div_sel_mean;
		logic update;
		logic load_out;
	} rir_cmd_t;

	typedef struct packed {
		logic have_prev;
		logic vol_zero;
		logic held_nz;
		logic div_busy;
		logic div_done;
	} rir_sts_t;

endpackage

`default_nettype wire

@@ hdl/rir_div.sv @@
`default_nettype none

module rir_div #(
	parameter int DVD_W = 80
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [DVD_W-1:0]            dividend,
	input  wire logic [rir_pkg::PROD_W-1:0]  divisor,
	output logic                             busy,
	output logic                             done,
	output logic [rir_pkg::TERM_W-1:0]       quotient,
	output logic                             overflow
);

	localparam int DVS_W = rir_pkg::PROD_W;
	localparam int Q_W   = rir_pkg::TERM_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [Q_W-1:0]   quo_q;
	logic             ovf_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] sub;
	logic           ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign sub   = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? sub[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[Q_W-1];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
	assign overflow = ovf_q;

endmodule

`default_nettype wire

@@ hdl/rir_dp.sv @@
`default_nettype none

module rir_dp #(
	parameter int MAX_WINDOW_TERMS   = rir_pkg::MAX_WINDOW_TERMS_DEF,
	parameter int TERM_FRACTION_BITS = rir_pkg::TERM_FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rir_pkg::rir_cmd_t             cmd,
	output rir_pkg::rir_sts_t                  sts,
	input  wire logic [rir_pkg::PRICE_W-1:0]   close_price,
	input  wire logic [rir_pkg::VOL_W-1:0]     volume,
	input  wire logic                          window_bars_we,
	input  wire logic [rir_pkg::WINDOW_W-1:0]  window_bars,
	output logic [rir_pkg::TERM_W-1:0]         illiquidity_mean,
	output logic                               result_valid
);

	localparam int PRICE_W = rir_pkg::PRICE_W;
	localparam int PROD_W  = rir_pkg::PROD_W;
	localparam int SUM_W   = rir_pkg::SUM_W;
	localparam int TERM_W  = rir_pkg::TERM_W;
	localparam int NUM_W   = PRICE_W + TERM_FRACTION_BITS;
	localparam int DVD_W   = (NUM_W > SUM_W) ? NUM_W : SUM_W;
	localparam int PTR_W   = $clog2(MAX_WINDOW_TERMS);
	localparam int CNT_W   = $clog2(MAX_WINDOW_TERMS + 1);
	localparam int CAP_W   = (CNT_W > rir_pkg::WINDOW_W + 1) ? CNT_W : rir_pkg::WINDOW_W + 1;

	logic [rir_pkg::WINDOW_W-1:0] window_q;
	logic [PRICE_W-1:0]           prev_q;
	logic                         have_prev_q;
	logic [PTR_W-1:0]             ptr_q;
	logic [CNT_W-1:0]             held_q;
	logic [SUM_W-1:0]             sum_q;

	logic [PRICE_W-1:0]       close_q;
	logic [rir_pkg::VOL_W-1:0] vol_q;
	logic [PRICE_W-1:0]       diff_q;
	logic [PROD_W-1:0]        prod_q;
	logic [TERM_W-1:0]        rd_q;
	logic [TERM_W-1:0]        mean_q;
	logic                     valid_q;

	logic [TERM_W-1:0] ring_mem [MAX_WINDOW_TERMS];

	logic [CAP_W-1:0]  cap_wide;
	logic [CNT_W-1:0]  cap;
	logic [CNT_W-1:0]  ptr_inc;
	logic              full;
	logic [PRICE_W-1:0] price_div;
	logic [NUM_W-1:0]  num;
	logic [DVD_W-1:0]  div_dividend;
	logic [PROD_W-1:0] div_divisor;
	logic              div_busy;
	logic              div_done;
	logic [TERM_W-1:0] div_quo;
	logic              div_ovf;
	logic [TERM_W-1:0] term;
	logic              ring_we;

	assign cap_wide = CAP_W'(window_q) + 1'b1;
	assign cap      = (cap_wide > CAP_W'(MAX_WINDOW_TERMS)) ? CNT_W'(MAX_WINDOW_TERMS)
	                                                        : CNT_W'(cap_wide);
	assign ptr_inc  = CNT_W'(ptr_q) + 1'b1;
	assign full     = held_q >= cap;

	assign price_div = (prev_q != '0) ? prev_q : rir_pkg::PRICE_ONE;
	assign num       = {diff_q, {TERM_FRACTION_BITS{1'b0}}};

	assign div_dividend = cmd.div_sel_mean ? DVD_W'(sum_q) : DVD_W'(num);
	assign div_divisor  = cmd.div_sel_mean ? PROD_W'(held_q) : prod_q;

	rir_div #(
		.DVD_W(DVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo),
		.overflow (div_ovf)
	);

	assign term    = (vol_q == '0) ? '0 : (div_ovf ? '1 : div_quo);
	assign ring_we = cmd.update && have_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= rir_pkg::WINDOW_RESET;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			ptr_q       <= '0;
			held_q      <= '0;
			sum_q       <= '0;
		end else if (window_bars_we) begin
			window_q <= window_bars;
			ptr_q    <= '0;
			held_q   <= '0;
			sum_q    <= '0;
		end else if (cmd.update) begin
			prev_q      <= close_q;
			have_prev_q <= 1'b1;
			if (have_prev_q) begin
				sum_q  <= sum_q - (full ? SUM_W'(rd_q) : '0) + SUM_W'(term);
				held_q <= full ? cap : held_q + 1'b1;
				ptr_q  <= (ptr_inc >= cap) ? '0 : ptr_inc[PTR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			close_q <= close_price;
			vol_q   <= volume;
		end
		if (cmd.prep) begin
			diff_q <= (close_q >= prev_q) ? close_q - prev_q : prev_q - close_q;
			prod_q <= price_div * vol_q;
		end
		if (cmd.load_out) begin
			mean_q  <= (held_q != '0) ? div_quo : '0;
			valid_q <= held_q != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ptr_q] <= term;
		end
		rd_q <= ring_mem[ptr_q];
	end

	assign sts.have_prev = have_prev_q;
	assign sts.vol_zero  = vol_q == '0;
	assign sts.held_nz   = held_q != '0;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;

	assign illiquidity_mean = mean_q;
	assign result_valid     = valid_q;

endmodule

`default_nettype wire

@@ hdl/rir_ctrl.sv @@
`default_nettype none

module rir_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rir_pkg::rir_cmd_t       cmd,
	input  wire rir_pkg::rir_sts_t  sts
);

	rir_pkg::rir_state_t state_q;
	rir_pkg::rir_state_t state_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rir_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rir_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = rir_pkg::ST_PREP;
				end
			end
			rir_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = (sts.have_prev && !sts.vol_zero) ? rir_pkg::ST_TERM_GO
				                                            : rir_pkg::ST_UPDATE;
			end
			rir_pkg::ST_TERM_GO: begin
				cmd.div_start = 1'b1;
				state_d       = rir_pkg::ST_TERM_WAIT;
			end
			rir_pkg::ST_TERM_WAIT: begin
				if (sts.div_done) begin
					state_d = rir_pkg::ST_UPDATE;
				end
			end
			rir_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = rir_pkg::ST_MEAN_GO;
			end
			rir_pkg::ST_MEAN_GO: begin
				cmd.div_sel_mean = 1'b1;
				if (sts.held_nz) begin
					cmd.div_start = 1'b1;
					state_d       = rir_pkg::ST_MEAN_WAIT;
				end else begin
					state_d = rir_pkg::ST_FINISH;
				end
			end
			rir_pkg::ST_MEAN_WAIT: begin
				if (sts.div_done) begin
					state_d = rir_pkg::ST_FINISH;
				end
			end
			rir_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = rir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rir_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/rolling_illiquidity_ratio.sv @@
// Rolling Amihud illiquidity ratio over price bars. Each input word carries a Q16.16 close
// price and an integer volume; each bar yields one output word with the mean of the most
// recent window_bars + 1 return terms |dP| / (P_prev * volume) in Q8.48 (result_valid low and
// mean zero until a term exists). One bar is processed at a time: the single radix-2
// restoring divider, with a dividend of DW = max(32 + TERM_FRACTION_BITS, 64) bits, runs
// the term division and then the mean division of a bar at one quotient bit per cycle.
// Zero-volume bars skip the term division; the first bar after reset holds no term and
// skips both divisions. The input is ready only between bars; a finished result sits in
// an output register, so the next bar is taken while it waits downstream.
// Writing window_bars clears the held terms and sum but keeps the previous close; write it
// only while the block is idle. The term ring needs no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module rolling_illiquidity_ratio #(
	parameter int MAX_WINDOW_TERMS   = rir_pkg::MAX_WINDOW_TERMS_DEF,
	parameter int TERM_FRACTION_BITS = rir_pkg::TERM_FRACTION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // close_price[31:0], volume[63:32]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // illiquidity_mean[55:0]
	output logic             m_axis_tuser,   // result_valid[0]
	input  wire logic        window_bars_we,
	input  wire logic [7:0]  window_bars
);

	rir_pkg::rir_cmd_t cmd;
	rir_pkg::rir_sts_t sts;

	rir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rir_dp #(
		.MAX_WINDOW_TERMS   (MAX_WINDOW_TERMS),
		.TERM_FRACTION_BITS (TERM_FRACTION_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.close_price      (s_axis_tdata[31:0]),
		.volume           (s_axis_tdata[63:32]),
		.window_bars_we   (window_bars_we),
		.window_bars      (window_bars),
		.illiquidity_mean (m_axis_tdata),
		.result_valid     (m_axis_tuser)
	);

	`RIR_ASSERT_IMP(a_div_idle_start, clk, arst_n, cmd.div_start, !sts.div_busy, "divider restarted while busy")
	`RIR_ASSERT_NXT(a_one_word_in, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken during a bar")
	`RIR_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.load_out, !m_axis_tvalid || m_axis_tready, "held result overwritten")
	`RIR_ASSERT_IMP(a_invalid_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "invalid result carries nonzero mean")

endmodule

`default_nettype wire

@@ test/rolling_illiquidity_ratio_test.sv @@
`default_nettype none

module rolling_illiquidity_ratio_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRICE_W = rir_pkg::PRICE_W;
	localparam int VOL_W = rir_pkg::VOL_W;
	localparam int SUM_W = rir_pkg::SUM_W;
	localparam int TERM_W = rir_pkg::TERM_W;
	localparam int WINDOW_W = rir_pkg::WINDOW_W;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = rir_pkg::WINDOW_RESET;
	localparam logic [PRICE_W-1:0] PRICE_ONE = rir_pkg::PRICE_ONE;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 200;
	localparam int RING_DEPTH = rir_pkg::MAX_WINDOW_TERMS_DEF;
	localparam int FRAC_BITS = rir_pkg::TERM_FRACTION_BITS_DEF;
	localparam logic [TERM_W-1:0] TERM_MAX = '1;

	typedef enum bit {
		ROW_BAR,
		ROW_WINDOW
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [PRICE_W-1:0]  close;   // window value on a ROW_WINDOW row
		logic [VOL_W-1:0]    vol;
		bit                  typed;
		logic [TERM_W-1:0]   mean;
		logic                valid;
	} bar_row_t;

	typedef struct packed {
		logic [TERM_W-1:0] mean;
		logic              valid;
	} ratio_word_t;

	localparam int N_ROWS = 22;

	bar_row_t directed_rows [0:N_ROWS-1] = '{
		'{ROW_BAR,    32'h0001_0000, 32'h0000_0001, 1'b1, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0002_0000, 32'h0000_0001, 1'b1, 56'h1_0000_0000_0000, 1'b1},
		'{ROW_BAR,    32'h0002_0000, 32'h0000_0000, 1'b1, 56'h0_8000_0000_0000, 1'b1},
		'{ROW_BAR,    32'h0000_0000, 32'h0000_0001, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0000_0001, 32'h0000_0001, 1'b0, 56'h0,              1'b0},
		'{ROW_WINDOW, 32'h0000_0000, 32'h0000_0000, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0000_0002, 32'h0000_0001, 1'b1, 56'h1_0000_0000_0000, 1'b1},
		'{ROW_BAR,    32'h0000_0002, 32'h0000_0005, 1'b1, 56'h0,              1'b1},
		'{ROW_BAR,    32'h0001_8000, 32'h0000_0003, 1'b0, 56'h0,              1'b0},
		'{ROW_WINDOW, 32'h0000_00FF, 32'h0000_0000, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0000_0000, 32'h0000_0000, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0000_0000, 32'h0000_0001, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 56'h0,              1'b0},
		'{ROW_WINDOW, 32'h0000_0001, 32'h0000_0000, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0001_0000, 32'h0000_0002, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0002_0000, 32'h0000_0002, 1'b0, 56'h0,              1'b0},
		'{ROW_BAR,    32'h0003_0000, 32'h0000_0002, 1'b0, 56'h0,              1'b0}
	};

	localparam int N_PHASES = 10;
	int phase_window [0:N_PHASES-1] = '{0, 255, 1, 30, -1, 7, 254, -1, 2, -1};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [63:0]         s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [55:0]         m_axis_tdata;
	logic                m_axis_tuser;
	logic                window_bars_we = 1'b0;
	logic [7:0]          window_bars = '0;

	rolling_illiquidity_ratio i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.window_bars_we (window_bars_we),
		.window_bars    (window_bars)
	);

	// shadow state of the ratio engine
	logic [WINDOW_W-1:0] sh_window = WINDOW_RESET;
	logic [PRICE_W-1:0]  sh_prev_close = '0;
	bit                  sh_have_prev = 1'b0;
	logic [TERM_W-1:0]   sh_terms [0:RING_DEPTH-1];
	int                  sh_slot = 0;
	int                  sh_held = 0;
	logic [SUM_W-1:0]    sh_sum = '0;

	ratio_word_t pending_means [$];
	int  failures = 0;
	int  words_checked = 0;
	int  bars_sent = 0;
	int  window_writes = 0;
	int  cycles = 0;
	bit  src_burst = 1'b0;
	bit  dst_burst = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [TERM_W-1:0] return_term(input logic [PRICE_W-1:0] prev,
			input logic [PRICE_W-1:0] close, input logic [VOL_W-1:0] vol);
		logic [PRICE_W-1:0] diff;
		logic [PRICE_W-1:0] base;
		logic [127:0]       den;
		logic [127:0]       quo;
		if (vol == '0)
			return '0;
		diff = (close >= prev) ? close - prev : prev - close;
		base = (prev != '0) ? prev : PRICE_ONE;
		den = 128'(base) * 128'(vol);
		quo = (128'(diff) << FRAC_BITS) / den;
		if (quo > 128'(TERM_MAX))
			return TERM_MAX;
		return quo[TERM_W-1:0];
	endfunction

	function automatic ratio_word_t track_bar(input logic [PRICE_W-1:0] close,
			input logic [VOL_W-1:0] vol);
		ratio_word_t       w;
		logic [TERM_W-1:0] term;
		int                cap;
		w = '0;
		cap = int'(sh_window) + 1;
		if (cap > RING_DEPTH)
			cap = RING_DEPTH;
		if (sh_have_prev) begin
			term = return_term(sh_prev_close, close, vol);
			if (sh_slot >= cap)
				sh_slot = 0;
			if (sh_held >= cap) begin
				sh_sum = sh_sum - SUM_W'(sh_terms[sh_slot]);
				sh_held = cap;
			end else begin
				sh_held++;
			end
			sh_terms[sh_slot] = term;
			sh_sum = sh_sum + SUM_W'(term);
			sh_slot++;
			if (sh_slot >= cap)
				sh_slot = 0;
		end
		sh_prev_close = close;
		sh_have_prev = 1'b1;
		if (sh_held != 0) begin
			w.mean = TERM_W'(sh_sum / SUM_W'(sh_held));
			w.valid = 1'b1;
		end
		return w;
	endfunction

	function automatic logic [PRICE_W-1:0] draw_close();
		logic [PRICE_W-1:0] step;
		case ($urandom_range(0, 7))
			5: return '0;
			6: return '1;
			7: return $urandom;
			default: begin
				step = PRICE_W'($urandom_range(0, 1 << $urandom_range(0, 20)));
				return $urandom_range(0, 1) ? sh_prev_close + step : sh_prev_close - step;
			end
		endcase
	endfunction

	function automatic logic [VOL_W-1:0] draw_volume();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3, 4, 5, 6: return $urandom;
			default: return $urandom_range(1, 5000);
		endcase
	endfunction

	// leaves tvalid high after acceptance so back-to-back words need no bubble
	task automatic send_bar(input logic [PRICE_W-1:0] close, input logic [VOL_W-1:0] vol,
			input bit typed, input ratio_word_t typed_word);
		int          gap;
		ratio_word_t w;
		if ($urandom_range(0, 15) == 0)
			src_burst = !src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {vol, close};
		do @(posedge clk); while (!s_axis_tready);
		w = track_bar(close, vol);
		pending_means.push_back(typed ? typed_word : w);
		bars_sent++;
	endtask

	task automatic write_window(input logic [WINDOW_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		window_bars_we <= 1'b1;
		window_bars <= value;
		@(posedge clk);
		window_bars_we <= 1'b0;
		sh_window = value;
		sh_slot = 0;
		sh_held = 0;
		sh_sum = '0;
		window_writes++;
	endtask

	always begin
		int          stall;
		ratio_word_t exp_word;
		if ($urandom_range(0, 15) == 0)
			dst_burst = !dst_burst;
		stall = dst_burst ? 0 : $urandom_range(0, 7);
		if (stall != 0) begin
			m_axis_tready <= 1'b0;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			repeat (stall - 1) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
		do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		words_checked++;
		if (pending_means.size() == 0) begin
			$error("output word with no bar pending: mean %h valid %b",
				m_axis_tdata, m_axis_tuser);
			failures++;
		end else begin
			exp_word = pending_means.pop_front();
			if (m_axis_tdata !== exp_word.mean) begin
				$error("illiquidity_mean: expected %h, got %h", exp_word.mean, m_axis_tdata);
				failures++;
			end
			if (m_axis_tuser !== exp_word.valid) begin
				$error("result_valid: expected %b, got %b", exp_word.valid, m_axis_tuser);
				failures++;
			end
		end
	end

	initial begin
		int          n_items;
		int          win;
		ratio_word_t typed_word;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WINDOW) begin
				write_window(directed_rows[i].close[WINDOW_W-1:0]);
			end else begin
				typed_word.mean = directed_rows[i].mean;
				typed_word.valid = directed_rows[i].valid;
				send_bar(directed_rows[i].close, directed_rows[i].vol,
					directed_rows[i].typed, typed_word);
			end
		end

		typed_word = '0;
		for (int p = 0; p < N_PHASES; p++) begin
			win = (phase_window[p] < 0) ? $urandom_range(0, 255) : phase_window[p];
			write_window(WINDOW_W'(win));
			n_items = (win >= 254) ? 290 : 90;
			for (int k = 0; k < n_items; k++)
				send_bar(draw_close(), draw_volume(), 1'b0, typed_word);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_means.size() != 0) begin
			$error("%0d expected words never arrived", pending_means.size());
			failures++;
		end
		$display("%0d bars over %0d window settings, %0d output words checked in %0d cycles",
			bars_sent, window_writes + 1, words_checked, cycles);
		if (failures == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d field mismatches", failures);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
